>>> rtl/pli_pkg.sv
// pli_pkg: shared types and codes for the positional list insert block
// transfer structs, status codes, cell commands and sequencer states
// no dependencies
package pli_pkg;

	localparam int POS_W = 8;
	localparam int VAL_W = 32;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_INVALID = 2'd1,
		ST_FULL    = 2'd2
	} st_t;

	// one input transfer
	typedef struct packed {
		logic [POS_W-1:0]        position;
		logic signed [VAL_W-1:0] value;
	} item_t;

	// one result transfer
	typedef struct packed {
		st_t                     status;
		logic                    direction;
		logic signed [VAL_W-1:0] entry;
		logic                    last;
	} result_t;

	// what every cell does in a cycle
	typedef enum logic [1:0] {
		OP_HOLD   = 2'd0,
		OP_INSERT = 2'd1,
		OP_ROT_DN = 2'd2,
		OP_ROT_UP = 2'd3
	} cell_op_t;

	// command broadcast from the sequencer to the cell row
	typedef struct packed {
		cell_op_t                op;
		logic [POS_W-1:0]        pos;
		logic [POS_W-1:0]        cnt;
		logic signed [VAL_W-1:0] value;
	} cell_cmd_t;

	// sequencer states
	typedef enum logic [1:0] {
		S_IDLE = 2'd0,
		S_FWD  = 2'd1,
		S_BWD  = 2'd2
	} state_t;

endpackage

>>> rtl/pli_cell.sv
// pli_cell: one storage cell of the list row
// holds one entry; loads the new value, a neighbor's, head or tail
// depends on pli_pkg
module pli_cell import pli_pkg::*; #(
	parameter int IDX = 0
) (
	input  logic                    clk,
	input  cell_cmd_t               cmd,
	input  logic signed [VAL_W-1:0] lo,
	input  logic signed [VAL_W-1:0] hi,
	input  logic signed [VAL_W-1:0] head,
	input  logic signed [VAL_W-1:0] tail,
	output logic signed [VAL_W-1:0] entry,
	output logic signed [VAL_W-1:0] tap
);

	logic signed [VAL_W-1:0] entry_q;
	logic                    is_tail;
	logic                    in_list;

	// position of this cell relative to the stored count
	assign is_tail = (POS_W'(IDX + 1) == cmd.cnt);
	assign in_list = (POS_W'(IDX) < cmd.cnt);

	// entry update
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_INSERT: begin
				if (POS_W'(IDX) == cmd.pos) begin
					entry_q <= cmd.value;
				end else if (POS_W'(IDX) > cmd.pos) begin
					entry_q <= lo;
				end
			end
			OP_ROT_DN: begin
				if (is_tail) begin
					entry_q <= head;
				end else if (in_list) begin
					entry_q <= hi;
				end
			end
			OP_ROT_UP: begin
				if (IDX == 0) begin
					entry_q <= tail;
				end else if (in_list) begin
					entry_q <= lo;
				end
			end
			default: begin
				entry_q <= entry_q;
			end
		endcase
	end

	assign entry = entry_q;
	// only the tail cell drives its value onto the tail bus
	assign tap = is_tail ? entry_q : '0;

endmodule

>>> rtl/pli_ctrl.sv
// pli_ctrl: sequencer for the positional list insert block
// keeps the count, checks each item, steps the readout and registers results
// depends on pli_pkg
module pli_ctrl import pli_pkg::*; #(
	parameter int CAPACITY = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  item_t                   item,
	output result_t                 result,
	output logic                    strobe,
	output cell_cmd_t               cmd,
	input  logic signed [VAL_W-1:0] head,
	input  logic signed [VAL_W-1:0] tail
);

	localparam int CW = $clog2(CAPACITY + 1);

	state_t          state_q, state_d;
	logic [CW-1:0]   count_q;
	logic [CW-1:0]   step_q;
	logic            strobe_q, strobe_d;
	result_t         result_q, result_d;
	logic            accept;
	logic            bad_pos;
	logic            full;
	logic            last_step;

	assign busy      = (state_q != S_IDLE);
	assign accept    = start && !busy;
	assign bad_pos   = (item.position > POS_W'(count_q));
	assign full      = (count_q == CW'(CAPACITY));
	assign last_step = (CW'(step_q + CW'(1)) == count_q);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept && !bad_pos && !full) begin
					state_d = S_FWD;
				end
			end
			S_FWD: begin
				if (last_step) begin
					state_d = S_BWD;
				end
			end
			S_BWD: begin
				if (last_step) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// cell command and next result
	always_comb begin
		cmd.op    = OP_HOLD;
		cmd.pos   = item.position;
		cmd.cnt   = POS_W'(count_q);
		cmd.value = item.value;
		strobe_d  = 1'b0;
		result_d  = '{status: ST_OK, direction: 1'b0, entry: '0, last: 1'b0};
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					strobe_d = bad_pos || full;
					if (bad_pos) begin
						result_d.status = ST_INVALID;
						result_d.last   = 1'b1;
					end else if (full) begin
						result_d.status = ST_FULL;
						result_d.last   = 1'b1;
					end else begin
						cmd.op = OP_INSERT;
					end
				end
			end
			S_FWD: begin
				cmd.op          = OP_ROT_DN;
				strobe_d        = 1'b1;
				result_d.entry  = head;
			end
			S_BWD: begin
				cmd.op             = OP_ROT_UP;
				strobe_d           = 1'b1;
				result_d.direction = 1'b1;
				result_d.entry     = tail;
				result_d.last      = last_step;
			end
			default: begin
				cmd.op = OP_HOLD;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			step_q   <= '0;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			strobe_q <= strobe_d;
			if (cmd.op == OP_INSERT) begin
				count_q <= CW'(count_q + CW'(1));
			end
			if (busy) begin
				step_q <= last_step ? '0 : CW'(step_q + CW'(1));
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		result_q <= result_d;
	end

	assign result = result_q;
	assign strobe = strobe_q;

endmodule

>>> rtl/positional_list_insert.sv
// positional_list_insert: top level, sequencer plus a row of storage cells
// ordered list of signed words with insert at a given position and readout
// depends on pli_pkg, pli_cell, pli_ctrl
//
//  channel | ports                 | transfer
//  --------+-----------------------+-------------------------------------
//  input   | start, busy, item     | start high and busy low at a clock edge
//  result  | strobe, result        | strobe high for one cycle per result
//
// A good insert starts with the accept cycle, in which the cell row shifts
// the new value in; then, with busy high, the row rotates toward the head
// through every entry and then back again, each rotation step giving one
// result.
// A bad position or a full list gets a single error result; busy stays low.
// Each result is registered and shows in the cycle after the step that made it.
// Reset clears the count and the sequencer; cell contents are left as is.
// The receiver cannot stall; results are never held.
module positional_list_insert import pli_pkg::*; #(
	parameter int CAPACITY = 16
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  item_t   item,
	output result_t result,
	output logic    strobe
);

	cell_cmd_t               cmd;
	logic signed [VAL_W-1:0] cell_q [CAPACITY];
	logic signed [VAL_W-1:0] tap    [CAPACITY];
	logic signed [VAL_W-1:0] tail;

	pli_ctrl #(
		.CAPACITY(CAPACITY)
	) u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.item  (item),
		.result(result),
		.strobe(strobe),
		.cmd   (cmd),
		.head  (cell_q[0]),
		.tail  (tail)
	);

	// row of cells, each wired to its neighbors; edge inputs tied to zero
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [VAL_W-1:0] lo;
		logic signed [VAL_W-1:0] hi;
		if (i == 0) begin : g_lo_edge
			assign lo = '0;
		end else begin : g_lo
			assign lo = cell_q[i-1];
		end
		if (i == CAPACITY - 1) begin : g_hi_edge
			assign hi = '0;
		end else begin : g_hi
			assign hi = cell_q[i+1];
		end
		pli_cell #(
			.IDX(i)
		) u_cell (
			.clk  (clk),
			.cmd  (cmd),
			.lo   (lo),
			.hi   (hi),
			.head (cell_q[0]),
			.tail (tail),
			.entry(cell_q[i]),
			.tap  (tap[i])
		);
	end

	// tail bus: only the tail cell drives a nonzero tap
	always_comb begin
		tail = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			tail = tail | tap[i];
		end
	end

endmodule

>>> rtl/pli_checker.sv
// pli_checker: port-level assertions for positional_list_insert
// attached to the top level by the bind statement below
// depends on pli_pkg
module pli_checker import pli_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    start,
	input logic    busy,
	input item_t   item,
	input result_t result,
	input logic    strobe
);

	// an error result is always the only result of its item
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (result.status != ST_OK) |-> result.last)
		else $error("error result without last");

	// an accepted item either answers at once or starts a readout
	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> strobe || busy)
		else $error("accepted item produced nothing");

	// the final result of an item comes as the block goes idle
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.last |-> !busy)
		else $error("last result while still busy");

	// more results are due while an earlier one is not the last
	a_more: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.last |-> busy)
		else $error("non-last result while idle");

	// leaving a readout always delivers the final transfer
	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> strobe && result.last)
		else $error("readout ended without last result");

endmodule

bind positional_list_insert pli_checker u_pli_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.item  (item),
	.result(result),
	.strobe(strobe)
);
